// ----- src/ips_pkg.sv -----
// ----------------------------------------------------------------------------
// ips_pkg
// Shared types, constants and the phase pair table of the crossing scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package ips_pkg;

   localparam int NUM_LANES          = 8;
   localparam int NUM_PHASES         = 13;
   localparam int LANE_BITS          = 3;
   localparam int PHASE_BITS         = 4;
   localparam int ARRIVE_BITS        = 8;
   localparam int QUEUE_BITS_DEFAULT = 16;
   localparam int REQ_DATA_BITS      = NUM_LANES * ARRIVE_BITS;
   localparam int RSP_DATA_BITS      = 16;

   typedef logic [ARRIVE_BITS-1:0] arrive_type;
   typedef logic [LANE_BITS-1:0]   lane_type;
   typedef logic [PHASE_BITS-1:0]  phase_type;
   typedef logic [NUM_LANES-1:0]   lane_mask_type;

   localparam phase_type PHASE_OFF = 4'd0;

   // movement pairs of each phase, phase zero is all lights off
   localparam lane_type PAIR_FIRST [NUM_PHASES] = '{
      3'd0, 3'd0, 3'd4, 3'd1, 3'd5, 3'd0, 3'd2, 3'd4, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3
   };
   localparam lane_type PAIR_SECOND [NUM_PHASES] = '{
      3'd0, 3'd2, 3'd6, 3'd3, 3'd7, 3'd1, 3'd3, 3'd5, 3'd7, 3'd7, 3'd4, 3'd5, 3'd6
   };

   // what the chosen phase serves during one transfer
   typedef struct packed {
      phase_type phase;
      lane_type  first_lane;
      logic      first_green;
      lane_type  second_lane;
      logic      second_green;
   } service_type;

endpackage

`default_nettype wire

// ----- src/intersection_phase_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// intersection_phase_scheduler_unit
// Traffic light phase scheduler for a four-way crossing with eight movements.
// ----------------------------------------------------------------------------
// One req transfer is one tick: eight 8-bit arrival counts, movement 0 in the
// lowest byte. One rsp transfer per tick gives the chosen phase, its two
// movements and which of them are green.
// The req side lands in an input register; queue update and phase choice are
// done in one pass of logic from that register into the rsp register.
// A tick passes from the input register into the rsp register, where it raises
// rsp_tvalid; the rsp transfer takes place at an edge with rsp_tready high.
// Throughput: one tick per cycle while rsp_tready stays high, limited only by
// the single update pass of the queue counters and the current phase register.
// Reset clears both valid flags, all queue counters and sets the phase to zero
// (all lights off). When the receiver stalls, the result holds in the rsp
// register and one more tick waits in the input register; req_tready drops
// only once both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module intersection_phase_scheduler_unit #(
   parameter int QUEUE_BITS = ips_pkg::QUEUE_BITS_DEFAULT
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   // arrive_a_straight, arrive_a_right, arrive_b_straight, arrive_b_right,
   // arrive_c_straight, arrive_c_right, arrive_d_straight, arrive_d_right
   input  wire  [ips_pkg::REQ_DATA_BITS-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   // phase[3:0], first_lane[6:4], first_green[7], second_lane[10:8],
   // second_green[11], zero fill[15:12]
   output logic [ips_pkg::RSP_DATA_BITS-1:0]      rsp_tdata
);
   import ips_pkg::*;

   logic          in_valid_ff;
   logic          in_valid_in;
   arrive_type    in_arrive_ff [NUM_LANES];
   logic          out_valid_ff;
   logic          out_valid_in;
   service_type   out_service_ff;
   logic          fire;
   logic          req_take;
   service_type   service;
   lane_mask_type occ;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign req_take   = req_tvalid && req_tready;

   ips_queue_bank #(
      .QUEUE_BITS(QUEUE_BITS)
   ) u_queue_bank (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .arrive  (in_arrive_ff),
      .service (service),
      .occ     (occ)
   );

   ips_phase_select u_phase_select (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .occ     (occ),
      .service (service)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            in_arrive_ff[i] <= req_tdata[i*ARRIVE_BITS +: ARRIVE_BITS];
         end
      end
      if (fire) begin
         out_service_ff <= service;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        out_service_ff.second_green,
                        out_service_ff.second_lane,
                        out_service_ff.first_green,
                        out_service_ff.first_lane,
                        out_service_ff.phase};

endmodule

`default_nettype wire

// ----- src/ips_phase_select.sv -----
// ----------------------------------------------------------------------------
// ips_phase_select
// Priority choice of the next phase from the occupancy bitmap; holds the
// current phase.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_phase_select (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   fire,
   input  ips_pkg::lane_mask_type occ,
   output ips_pkg::service_type  service
);
   import ips_pkg::*;

   phase_type current_phase_ff;
   phase_type current_phase_in;

   always_comb begin
      logic              both_found;
      logic              one_found;
      phase_type         both_phase;
      phase_type         one_phase;
      phase_type         pick;
      logic              cur_busy;
      both_found = 1'b0;
      one_found  = 1'b0;
      both_phase = PHASE_OFF;
      one_phase  = PHASE_OFF;
      // search from the top down so the lowest matching phase lands last
      for (int k = NUM_PHASES - 1; k >= 1; k--) begin
         if (phase_type'(k) != current_phase_ff) begin
            if (occ[PAIR_FIRST[k]] && occ[PAIR_SECOND[k]]) begin
               both_found = 1'b1;
               both_phase = phase_type'(k);
            end
            if (occ[PAIR_FIRST[k]] || occ[PAIR_SECOND[k]]) begin
               one_found = 1'b1;
               one_phase = phase_type'(k);
            end
         end
      end
      cur_busy = 1'b0;
      for (int k = 1; k < NUM_PHASES; k++) begin
         if (phase_type'(k) == current_phase_ff &&
             (occ[PAIR_FIRST[k]] || occ[PAIR_SECOND[k]])) begin
            cur_busy = 1'b1;
         end
      end
      if (both_found) begin
         pick = both_phase;
      end else if (one_found) begin
         pick = one_phase;
      end else if (cur_busy) begin
         pick = current_phase_ff;
      end else begin
         pick = PHASE_OFF;
      end
      service.phase = pick;
      if (pick == PHASE_OFF) begin
         service.first_lane   = '0;
         service.second_lane  = '0;
         service.first_green  = 1'b0;
         service.second_green = 1'b0;
      end else begin
         service.first_lane   = PAIR_FIRST[pick];
         service.second_lane  = PAIR_SECOND[pick];
         service.first_green  = occ[PAIR_FIRST[pick]];
         service.second_green = occ[PAIR_SECOND[pick]];
      end
   end

   always_comb begin
      current_phase_in = current_phase_ff;
      if (fire) begin
         current_phase_in = service.phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         current_phase_ff <= PHASE_OFF;
      end else begin
         current_phase_ff <= current_phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ips_queue_bank.sv -----
// ----------------------------------------------------------------------------
// ips_queue_bank
// Eight saturating queue counters: add arrivals, report occupancy, serve the
// green movements.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_queue_bank #(
   parameter int QUEUE_BITS = ips_pkg::QUEUE_BITS_DEFAULT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fire,
   input  ips_pkg::arrive_type    arrive [ips_pkg::NUM_LANES],
   input  ips_pkg::service_type   service,
   output ips_pkg::lane_mask_type occ
);
   import ips_pkg::*;

   localparam int SUM_BITS = ((QUEUE_BITS > ARRIVE_BITS) ? QUEUE_BITS : ARRIVE_BITS) + 1;
   localparam logic [SUM_BITS-1:0] QUEUE_MAX = SUM_BITS'((64'd1 << QUEUE_BITS) - 64'd1);

   typedef logic [QUEUE_BITS-1:0] queue_type;

   queue_type queue_ff [NUM_LANES];
   queue_type queue_in [NUM_LANES];
   queue_type filled   [NUM_LANES];

   always_comb begin
      logic [SUM_BITS-1:0] sum;
      logic                serve;
      for (int i = 0; i < NUM_LANES; i++) begin
         sum = SUM_BITS'(queue_ff[i]) + SUM_BITS'(arrive[i]);
         filled[i] = (sum > QUEUE_MAX) ? QUEUE_BITS'(QUEUE_MAX) : QUEUE_BITS'(sum);
         // nonzero after the add iff either term is nonzero
         occ[i] = (queue_ff[i] != '0) || (arrive[i] != '0);
         serve = (service.phase != PHASE_OFF) && occ[i] &&
                 ((service.first_lane == lane_type'(i)) ||
                  (service.second_lane == lane_type'(i)));
         queue_in[i] = queue_ff[i];
         if (fire) begin
            queue_in[i] = serve ? (filled[i] - queue_type'(1)) : filled[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES; i++) begin
            queue_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < NUM_LANES; i++) begin
            queue_ff[i] <= queue_in[i];
         end
      end
   end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the crossing phase scheduler.
// ----------------------------------------------------------------------------
// A short table of directed ticks comes first. It covers the empty crossing,
// single and paired movements, and a full arrival byte. A few of its rows
// carry a hand-written result. The other rows, and the random traffic after
// them, are checked against a behavioral scheduler inside the bench. The
// random traffic is made of quiet, light and heavy segments, so the queues
// fill and drain again. Then every queue is driven into saturation, then random
// ticks follow. The sender works in bursts with random gaps. The receiver stalls
// in modes that change from time to time.
// ----------------------------------------------------------------------------

module tb;
   import ips_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 9;
   localparam int QUEUE_BITS     = QUEUE_BITS_DEFAULT;
   localparam int DIRECTED_TICKS = 18;
   localparam int RANDOM_TICKS   = 1100;
   localparam int FLOOD_TICKS    = 300;
   localparam int NOISE_TICKS    = 100;
   localparam int DRAIN_CYCLES   = 16;
   localparam int CYCLE_LIMIT    = 200000;

   // movement pairs per phase, phase 12 in the top bits
   localparam logic [NUM_PHASES*LANE_BITS-1:0] FIRST_OF_PHASE =
      {3'd3, 3'd2, 3'd1, 3'd0, 3'd6, 3'd4, 3'd2, 3'd0, 3'd5, 3'd1, 3'd4, 3'd0, 3'd0};
   localparam logic [NUM_PHASES*LANE_BITS-1:0] SECOND_OF_PHASE =
      {3'd6, 3'd5, 3'd4, 3'd7, 3'd7, 3'd5, 3'd3, 3'd1, 3'd7, 3'd3, 3'd6, 3'd2, 3'd0};

   typedef struct packed {
      logic [REQ_DATA_BITS-1:0] arrivals;
      logic                     fixed;
      service_type              lights;
   } directed_tick_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   longint unsigned lane_queue [NUM_LANES];
   phase_type       active_phase;
   service_type     expected_lights [$];
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   int              burst_left     = 0;
   int              stall_mode     = 0;
   int              stall_left     = 0;

   // arrivals of lane m in bits [8m+7:8m]; a row with fixed set carries its result
   directed_tick_type directed_ticks [DIRECTED_TICKS] = '{
      '{64'h0000_0000_0000_0000, 1'b1, {4'd0, 3'd0, 1'b0, 3'd0, 1'b0}},
      '{64'h0000_0000_0000_0001, 1'b1, {4'd1, 3'd0, 1'b1, 3'd2, 1'b0}},
      '{64'h0000_0000_0000_0000, 1'b1, {4'd0, 3'd0, 1'b0, 3'd0, 1'b0}},
      '{64'h0000_0000_0001_0001, 1'b1, {4'd1, 3'd0, 1'b1, 3'd2, 1'b1}},
      '{64'hFF00_0000_0000_0000, 1'b1, {4'd4, 3'd5, 1'b0, 3'd7, 1'b1}},
      '{64'h0000_0000_0000_0000, 1'b1, {4'd8, 3'd6, 1'b0, 3'd7, 1'b1}},
      '{64'h0000_0000_0000_0000, 1'b1, {4'd4, 3'd5, 1'b0, 3'd7, 1'b1}},
      '{64'h0000_0000_0000_0200, 1'b0, '0},
      '{64'h0000_0000_0200_0000, 1'b0, '0},
      '{64'h0000_0001_0001_0000, 1'b0, '0},
      '{64'h0001_0000_0000_0000, 1'b0, '0},
      '{64'h0000_0100_0000_0000, 1'b0, '0},
      '{64'h0101_0101_0101_0101, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, '0},
      '{64'h8000_0000_0000_0080, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, '0},
      '{64'h0000_0000_0000_0000, 1'b0, '0}
   };

   intersection_phase_scheduler_unit #(
      .QUEUE_BITS(QUEUE_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // adds one tick of arrivals, picks the phase and serves its two movements
   function automatic service_type schedule_tick(input logic [REQ_DATA_BITS-1:0] arrivals);
      longint unsigned queue_limit;
      longint unsigned added;
      lane_mask_type   waiting;
      phase_type       pick;
      lane_type        lane_a;
      lane_type        lane_b;
      logic            found;
      service_type     lights;
      queue_limit = (64'd1 << QUEUE_BITS) - 64'd1;
      waiting     = '0;
      for (int m = 0; m < NUM_LANES; m++) begin
         added = 64'(arrivals[m*ARRIVE_BITS +: ARRIVE_BITS]);
         if (queue_limit - lane_queue[m] < added) begin
            lane_queue[m] = queue_limit;
         end else begin
            lane_queue[m] = lane_queue[m] + added;
         end
         waiting[m] = lane_queue[m] != 0;
      end
      pick  = PHASE_OFF;
      found = 1'b0;
      if (waiting != '0) begin
         // both movements waiting beats a single one; the current phase is skipped
         for (int pass = 0; pass < 2; pass++) begin
            for (int p = 1; p < NUM_PHASES; p++) begin
               lane_a = FIRST_OF_PHASE[p*LANE_BITS +: LANE_BITS];
               lane_b = SECOND_OF_PHASE[p*LANE_BITS +: LANE_BITS];
               if (!found && p != active_phase &&
                   (pass == 0 ? (waiting[lane_a] && waiting[lane_b])
                              : (waiting[lane_a] || waiting[lane_b]))) begin
                  pick  = phase_type'(p);
                  found = 1'b1;
               end
            end
         end
         if (!found && active_phase != PHASE_OFF && active_phase < NUM_PHASES) begin
            lane_a = FIRST_OF_PHASE[active_phase*LANE_BITS +: LANE_BITS];
            lane_b = SECOND_OF_PHASE[active_phase*LANE_BITS +: LANE_BITS];
            if (waiting[lane_a] || waiting[lane_b]) begin
               pick = active_phase;
            end
         end
      end
      lights       = '0;
      lights.phase = pick;
      if (pick != PHASE_OFF) begin
         lane_a              = FIRST_OF_PHASE[pick*LANE_BITS +: LANE_BITS];
         lane_b              = SECOND_OF_PHASE[pick*LANE_BITS +: LANE_BITS];
         lights.first_lane   = lane_a;
         lights.second_lane  = lane_b;
         lights.first_green  = lane_queue[lane_a] != 0;
         lights.second_green = lane_queue[lane_b] != 0;
         if (lane_queue[lane_a] != 0) begin
            lane_queue[lane_a]--;
         end
         if (lane_queue[lane_b] != 0) begin
            lane_queue[lane_b]--;
         end
      end
      active_phase = pick;
      return lights;
   endfunction

   // one req transfer; the sender idles between bursts of random length
   task automatic send_tick(input logic [REQ_DATA_BITS-1:0] arrivals, input logic fixed,
                            input service_type fixed_lights);
      int          idle_gap;
      service_type predicted;
      if (burst_left == 0) begin
         idle_gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (idle_gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (idle_gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= arrivals;
      do @(posedge clock); while (!req_tready);
      predicted = schedule_tick(arrivals);
      expected_lights.push_back(fixed ? fixed_lights : predicted);
   endtask

   task automatic compare_field(input string field_name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field_name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: checks each rsp transfer and stalls in changing modes
   always @(posedge clock) begin
      service_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_lights.size() == 0) begin
               $error("rsp transfer with no tick outstanding, rsp_tdata %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_lights.pop_front();
               compare_field("phase", int'(want.phase), int'(rsp_tdata[3:0]));
               compare_field("first_lane", int'(want.first_lane), int'(rsp_tdata[6:4]));
               compare_field("first_green", int'(want.first_green), int'(rsp_tdata[7]));
               compare_field("second_lane", int'(want.second_lane), int'(rsp_tdata[10:8]));
               compare_field("second_green", int'(want.second_green), int'(rsp_tdata[11]));
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 128);
         end else begin
            stall_left--;
         end
         case (stall_mode)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= $urandom_range(0, 3) != 0;
            end
            2: begin
               rsp_tready <= $urandom_range(0, 1) != 0;
            end
            default: begin
               // short windows of ready inside long stalls
               rsp_tready <= (cycle_count % 8) < 2;
            end
         endcase
      end
   end

   initial begin
      logic [REQ_DATA_BITS-1:0] arrivals;
      int                       segment;
      int                       segment_len;
      int                       sent;
      for (int m = 0; m < NUM_LANES; m++) begin
         lane_queue[m] = 0;
      end
      active_phase = PHASE_OFF;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_TICKS; r++) begin
         send_tick(directed_ticks[r].arrivals, directed_ticks[r].fixed,
                   directed_ticks[r].lights);
      end

      // quiet segments let the queues drain, heavy ones pile a lane up
      sent = 0;
      while (sent < RANDOM_TICKS) begin
         segment     = $urandom_range(0, 9);
         segment_len = (segment == 9) ? $urandom_range(1, 2) : $urandom_range(4, 40);
         for (int k = 0; k < segment_len && sent < RANDOM_TICKS; k++) begin
            arrivals = '0;
            if (segment == 9) begin
               arrivals[$urandom_range(0, NUM_LANES - 1)*ARRIVE_BITS +: ARRIVE_BITS] =
                  ARRIVE_BITS'($urandom_range(0, 255));
            end else if (segment >= 4) begin
               for (int m = 0; m < NUM_LANES; m++) begin
                  if ($urandom_range(0, 7) == 0) begin
                     arrivals[m*ARRIVE_BITS +: ARRIVE_BITS] =
                        ARRIVE_BITS'($urandom_range(1, 2));
                  end
               end
            end
            send_tick(arrivals, 1'b0, '0);
            sent++;
         end
      end

      // full arrivals on every lane drive all queues into saturation
      for (int k = 0; k < FLOOD_TICKS; k++) begin
         send_tick('1, 1'b0, '0);
      end
      for (int k = 0; k < NOISE_TICKS; k++) begin
         arrivals = {$urandom, $urandom};
         send_tick(arrivals, 1'b0, '0);
      end

      req_tvalid <= 1'b0;
      while (expected_lights.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
